@@ rtl/core/ppu_pkg.sv @@
`default_nettype none
package ppu_pkg;
    localparam int unsigned DT_W = 17;
    localparam int unsigned W = 32;
    localparam int unsigned UW = 31;
    localparam int unsigned AL_W = 8;
    localparam int unsigned AQ_W = 9;
    localparam logic [AL_W-1:0] ALPHA_MAX = 8'd255;
    localparam logic [4:0] GRAV = 5'd8;
    localparam logic signed [W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] S_MIN = 32'sh8000_0000;

    function automatic logic signed [W-1:0] sat34(input logic signed [W+1:0] v);
        if (v > 34'sh0_7FFF_FFFF) return S_MAX;
        if (v < -34'sh0_8000_0000) return S_MIN;
        return v[W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/particle_physics_update_core.sv @@
// A particle passes 14 register stages from the accepting edge to the result,
// which is presented with o_done.
// Throughput: one particle per cycle; busy is always low.
// Alpha quotient comes from a pipelined restoring divider, one bit per stage.
// Reset (synchronous, active low) clears all pipeline valid bits.
// The receiver cannot stall; results appear with o_done for one cycle.
`default_nettype none
module particle_physics_update_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ppu_pkg::DT_W-1:0]      i_dt,
    input  wire logic                          i_active,
    input  wire logic signed [ppu_pkg::W-1:0]  i_lifetime,
    input  wire logic [ppu_pkg::UW-1:0]        i_max_lifetime,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_x,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_y,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_z,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_x,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_y,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_z,
    input  wire logic [ppu_pkg::UW-1:0]        i_size,
    input  wire logic [ppu_pkg::UW-1:0]        i_size_decay,
    output logic                               o_done,
    output logic                               o_active_out,
    output logic signed [ppu_pkg::W-1:0]       o_lifetime_out,
    output logic signed [ppu_pkg::W-1:0]       o_pos_x_out,
    output logic signed [ppu_pkg::W-1:0]       o_pos_y_out,
    output logic signed [ppu_pkg::W-1:0]       o_pos_z_out,
    output logic signed [ppu_pkg::W-1:0]       o_vel_x_out,
    output logic signed [ppu_pkg::W-1:0]       o_vel_y_out,
    output logic signed [ppu_pkg::W-1:0]       o_vel_z_out,
    output logic [ppu_pkg::UW-1:0]             o_size_out,
    output logic [ppu_pkg::AL_W-1:0]           o_alpha,
    output logic                               o_alpha_written
);
    import ppu_pkg::*;

    localparam int unsigned PW = W + DT_W + 1;
    localparam logic signed [W:0] FLOOR_Y =
        (W+1)'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam int unsigned NDIV = AQ_W;

    typedef struct packed {
        logic                 v;
        logic                 act;
        logic                 alive;
        logic [DT_W-1:0]      dt;
        logic signed [W-1:0]  life;
        logic [UW-1:0]        maxl;
        logic signed [W-1:0]  px, py, pz, vx, vy, vz;
        logic [UW-1:0]        sz, dec;
    } t_rec;

    assign busy = 1'b0;

    // stage 1: lifetime, gravity
    t_rec r_s1;
    logic signed [W+1:0] n_life, n_vy;
    always_comb begin
        n_life = {{2{i_lifetime[W-1]}}, i_lifetime} - (W+2)'({1'b0, i_dt});
        n_vy = {{2{i_vel_y[W-1]}}, i_vel_y} - (W+2)'({1'b0, i_dt} * GRAV);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1.v <= 1'b0;
        else r_s1.v <= start;
        r_s1.act <= i_active;
        r_s1.dt <= i_dt;
        r_s1.maxl <= i_max_lifetime;
        r_s1.px <= i_pos_x; r_s1.py <= i_pos_y; r_s1.pz <= i_pos_z;
        r_s1.vx <= i_vel_x; r_s1.vz <= i_vel_z;
        r_s1.sz <= i_size; r_s1.dec <= i_size_decay;
        if (i_active) begin
            r_s1.life <= sat34(n_life);
            r_s1.vy <= (sat34(n_life) > 0) ? sat34(n_vy) : i_vel_y;
            r_s1.alive <= (sat34(n_life) > 0);
        end else begin
            r_s1.life <= i_lifetime;
            r_s1.vy <= i_vel_y;
            r_s1.alive <= 1'b0;
        end
    end

    // stage 2: products
    t_rec r_s2;
    logic signed [PW-1:0] r_mx, r_my, r_mz, r_md;
    logic signed [DT_W:0] s1_dt;
    assign s1_dt = {1'b0, r_s1.dt};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2.v <= 1'b0;
        else r_s2.v <= r_s1.v;
        r_s2[$bits(t_rec)-2:0] <= r_s1[$bits(t_rec)-2:0];
        r_mx <= PW'(r_s1.vx * s1_dt);
        r_my <= PW'(r_s1.vy * s1_dt);
        r_mz <= PW'(r_s1.vz * s1_dt);
        r_md <= PW'($signed({1'b0, r_s1.dec}) * s1_dt);
    end

    // stage 3: integrate
    t_rec r_s3;
    logic signed [PW-1:0] n_ax, n_ay, n_az, n_ad;
    logic signed [PW:0] n_px, n_py, n_pz, n_sz;
    logic n_bnc;
    always_comb begin
        n_ax = r_mx >>> FRAC_BITS;
        n_ay = r_my >>> FRAC_BITS;
        n_az = r_mz >>> FRAC_BITS;
        n_ad = r_md >>> FRAC_BITS;
        n_px = PW'(r_s2.px) + n_ax;
        n_py = PW'(r_s2.py) + n_ay;
        n_pz = PW'(r_s2.pz) + n_az;
        n_sz = (PW+1)'($signed({1'b0, r_s2.sz})) - n_ad;
    end
    function automatic logic signed [W-1:0] satw(input logic signed [PW:0] v);
        if (v > (PW+1)'(S_MAX)) return S_MAX;
        if (v < (PW+1)'(S_MIN)) return S_MIN;
        return v[W-1:0];
    endfunction
    logic signed [W-1:0] n_pys;
    assign n_pys = satw(n_py);
    assign n_bnc = ($signed({n_pys[W-1], n_pys}) < FLOOR_Y);
    logic r_bnc;
    t_rec n_s3;
    always_comb begin
        n_s3 = r_s2;
        if (r_s2.alive) begin
            n_s3.px = satw(n_px);
            n_s3.py = n_bnc ? FLOOR_Y[W-1:0] : n_pys;
            n_s3.pz = satw(n_pz);
            n_s3.sz = n_sz[PW] ? '0 : n_sz[UW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3.v <= 1'b0;
        else r_s3.v <= r_s2.v;
        r_s3[$bits(t_rec)-2:0] <= n_s3[$bits(t_rec)-2:0];
        r_bnc <= r_s2.alive & n_bnc;
    end

    // stage 4: bounce scale multiply (v*-3, v*8), alpha numerator
    t_rec r_s4;
    logic r_bnc4;
    logic signed [W+4:0] r_bx, r_by, r_bz;
    logic [W+7:0] r_anum;
    logic r_afull;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4.v <= 1'b0;
        else r_s4.v <= r_s3.v;
        r_s4[$bits(t_rec)-2:0] <= r_s3[$bits(t_rec)-2:0];
        r_bnc4 <= r_bnc;
        r_bx <= (W+5)'(r_s3.vx) <<< 3;
        r_bz <= (W+5)'(r_s3.vz) <<< 3;
        r_by <= -((W+5)'(r_s3.vy) * 3);
        r_anum <= (W+8)'(r_s3.life[UW-1:0]) * 255;
        r_afull <= (r_s3.maxl == '0) ||
                   ($signed(r_s3.life) >= $signed({1'b0, r_s3.maxl}));
    end

    // stage 5: floor divide by 10 via reciprocal multiply
    localparam logic [W+3:0] RECIP = 35'd3435973837; // ceil(2^35/10)
    function automatic logic signed [W+4:0] fdiv10(input logic signed [W+4:0] n);
        logic [W+4:0] m;
        logic [2*W+8:0] p;
        logic [W+4:0] q;
        m = n[W+4] ? ~n : n;
        p = (2*W+9)'(m) * (2*W+9)'(RECIP);
        q = (W+5)'(p >> 35);
        return n[W+4] ? ~q : q;
    endfunction
    t_rec r_s5;
    t_rec n_s5;
    logic [W+7:0] r_anum5;
    logic r_afull5;
    always_comb begin
        n_s5 = r_s4;
        if (r_bnc4) begin
            n_s5.vx = sat34((W+2)'(fdiv10(r_bx)));
            n_s5.vy = sat34((W+2)'(fdiv10(r_by)));
            n_s5.vz = sat34((W+2)'(fdiv10(r_bz)));
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5.v <= 1'b0;
        else r_s5.v <= r_s4.v;
        r_s5[$bits(t_rec)-2:0] <= n_s5[$bits(t_rec)-2:0];
        r_anum5 <= r_anum;
        r_afull5 <= r_afull;
    end

    // stages 6..14: restoring divider, one quotient bit per stage
    t_rec r_d [NDIV];
    logic [W+7:0] r_rem [NDIV];
    logic [AQ_W-1:0] r_q [NDIV];
    logic r_af [NDIV];
    genvar g;
    generate
        for (g = 0; g < NDIV; g++) begin : g_div
            t_rec p_r;
            logic [W+7:0] p_rem, sub;
            logic [AQ_W-1:0] p_q;
            logic p_af;
            logic ge;
            localparam int unsigned SH = NDIV - 1 - g;
            if (g == 0) begin : g_f
                assign p_r = r_s5; assign p_rem = r_anum5;
                assign p_q = '0; assign p_af = r_afull5;
            end else begin : g_n
                assign p_r = r_d[g-1]; assign p_rem = r_rem[g-1];
                assign p_q = r_q[g-1]; assign p_af = r_af[g-1];
            end
            assign sub = (W+8)'({1'b0, p_r.maxl}) << SH;
            assign ge = ((p_rem >> SH) >= (W+8)'({1'b0, p_r.maxl}));
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_d[g].v <= 1'b0;
                else r_d[g].v <= p_r.v;
                r_d[g][$bits(t_rec)-2:0] <= p_r[$bits(t_rec)-2:0];
                r_af[g] <= p_af;
                r_rem[g] <= ge ? p_rem - sub : p_rem;
                r_q[g] <= ge ? (p_q | (AQ_W'(1) << SH)) : p_q;
            end
        end
    endgenerate

    t_rec fin;
    assign fin = r_d[NDIV-1];
    assign o_done = fin.v;
    assign o_active_out = fin.alive;
    assign o_lifetime_out = fin.life;
    assign o_pos_x_out = fin.px;
    assign o_pos_y_out = fin.py;
    assign o_pos_z_out = fin.pz;
    assign o_vel_x_out = fin.vx;
    assign o_vel_y_out = fin.vy;
    assign o_vel_z_out = fin.vz;
    assign o_size_out = fin.sz;
    assign o_alpha_written = fin.alive;
    assign o_alpha = !fin.alive ? '0 :
                     (r_af[NDIV-1] || r_q[NDIV-1][AQ_W-1]) ? ALPHA_MAX :
                     r_q[NDIV-1][AL_W-1:0];
endmodule
`default_nettype wire

@@ tb/particle_physics_update_checker.sv @@
`timescale 1ns / 1ps
module particle_physics_update_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [ppu_pkg::DT_W-1:0]      i_dt,
    input  wire logic                          i_active,
    input  wire logic signed [ppu_pkg::W-1:0]  i_lifetime,
    input  wire logic [ppu_pkg::UW-1:0]        i_max_lifetime,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_x,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_y,
    input  wire logic signed [ppu_pkg::W-1:0]  i_pos_z,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_x,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_y,
    input  wire logic signed [ppu_pkg::W-1:0]  i_vel_z,
    input  wire logic [ppu_pkg::UW-1:0]        i_size,
    input  wire logic [ppu_pkg::UW-1:0]        i_size_decay,
    input  wire logic                          o_done,
    input  wire logic                          o_active_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_lifetime_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_pos_x_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_pos_y_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_pos_z_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_vel_x_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_vel_y_out,
    input  wire logic signed [ppu_pkg::W-1:0]  o_vel_z_out,
    input  wire logic [ppu_pkg::UW-1:0]        o_size_out,
    input  wire logic [ppu_pkg::AL_W-1:0]      o_alpha,
    input  wire logic                          o_alpha_written,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    typedef struct packed {
        logic        alive;
        logic [31:0] life;
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [30:0] sz;
        logic [7:0]  alpha;
        logic        aw;
    } t_particle;

    localparam longint FLOOR_Y = 3277;

    t_particle step_queue[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_particle advance(input longint dt);
        t_particle r;
        longint life, maxl, px, py, pz, vx, vy, vz, sz, dec, al;
        life = i_lifetime; maxl = i_max_lifetime;
        px = i_pos_x; py = i_pos_y; pz = i_pos_z;
        vx = i_vel_x; vy = i_vel_y; vz = i_vel_z;
        sz = i_size; dec = i_size_decay;
        r.alive = 0; r.alpha = 0; r.aw = 0;
        if (i_active) begin
            life = clamp32(life - dt);
            if (life > 0) begin
                r.alive = 1;
                vy = clamp32(vy - 8 * dt);
                px = clamp32(px + floor_div(vx * dt, 65536));
                py = clamp32(py + floor_div(vy * dt, 65536));
                pz = clamp32(pz + floor_div(vz * dt, 65536));
                sz = sz - floor_div(dec * dt, 65536);
                if (sz < 0) sz = 0;
                if (py < FLOOR_Y) begin
                    py = FLOOR_Y;
                    vy = clamp32(floor_div(-3 * vy, 10));
                    vx = clamp32(floor_div(8 * vx, 10));
                    vz = clamp32(floor_div(8 * vz, 10));
                end
                if (maxl == 0 || life >= maxl) al = 255;
                else al = floor_div(255 * life, maxl);
                r.alpha = al[7:0];
                r.aw = 1;
            end
        end
        r.life = life[31:0];
        r.px = px[31:0]; r.py = py[31:0]; r.pz = pz[31:0];
        r.vx = vx[31:0]; r.vy = vy[31:0]; r.vz = vz[31:0];
        r.sz = sz[30:0];
        return r;
    endfunction

    t_particle got, want;

    assign o_pending = step_queue.size();

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got = '{o_active_out, o_lifetime_out, o_pos_x_out, o_pos_y_out, o_pos_z_out,
                    o_vel_x_out, o_vel_y_out, o_vel_z_out, o_size_out, o_alpha,
                    o_alpha_written};
            if (step_queue.size() == 0) begin
                $display("%0t unexpected beat %h", $time, got);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = step_queue.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
        if (i_rst_n && start && !busy) step_queue.push_back(advance(longint'(i_dt)));
    end
endmodule

@@ tb/particle_physics_update_core_test.sv @@
`timescale 1ns / 1ps
module particle_physics_update_core_test;
    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic [16:0] i_dt = 0;
    logic i_active = 0;
    logic signed [31:0] i_lifetime = 0, i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic signed [31:0] i_vel_x = 0, i_vel_y = 0, i_vel_z = 0;
    logic [30:0] i_max_lifetime = 0, i_size = 0, i_size_decay = 0;
    logic o_done, o_active_out, o_alpha_written;
    logic signed [31:0] o_lifetime_out, o_pos_x_out, o_pos_y_out, o_pos_z_out;
    logic signed [31:0] o_vel_x_out, o_vel_y_out, o_vel_z_out;
    logic [30:0] o_size_out;
    logic [7:0] o_alpha;
    int fail_count, pending, cycles = 0;

    always #5 i_clk = ~i_clk;

    particle_physics_update_core dut (.*);
    particle_physics_update_checker chk (.*, .o_fail_count(fail_count),
        .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 20) << 16;
            3: return -($urandom_range(0, 20) << 16);
            4: return $urandom_range(0, 8191);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_particle(input logic [16:0] dt, input logic act,
                                 input logic [31:0] life, input logic [30:0] maxl,
                                 input logic [31:0] py, input logic [31:0] vy);
        @(negedge i_clk);
        start <= 1; i_dt <= dt; i_active <= act; i_lifetime <= life;
        i_max_lifetime <= maxl; i_pos_y <= py; i_vel_y <= vy;
        i_pos_x <= pick32(); i_pos_z <= pick32();
        i_vel_x <= pick32(); i_vel_z <= pick32();
        i_size <= 31'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 65536));
        i_size_decay <= 31'(($urandom_range(0, 1)) ? $urandom
                                                    : $urandom_range(0, 65536));
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30)
                                                : $urandom_range(0, 2)) @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        send_particle(0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        send_particle(17'h10000, 1, 32'h8000_0000, 100, 0, 0);
        send_particle(17'h10000, 1, 32'h10000, 100, 0, 0);
        send_particle(17'h10000, 1, 32'h10001, 0, 100000, 0);
        send_particle(0, 1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_particle(17'h10000, 1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000);
        send_particle(1, 1, 32'h20000, 31'h40000, 3277, 0);
        send_particle(1, 1, 32'h20000, 31'h10000, 3276, 32'h7FFF_FFFF);
        send_particle(17'h1FFFF, 1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 32'h8000_0000);
        send_particle(555, 1, 32'h0123_4567, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        repeat (2000) begin
            send_particle(17'($urandom_range(0, 5) == 0 ? $urandom
                                                        : $urandom_range(0, 65536)),
                          $urandom_range(0, 7) != 0,
                          $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 1 << 22),
                          31'($urandom_range(0, 5) == 0 ? $urandom
                                                        : $urandom_range(0, 1 << 22)),
                          pick32(), pick32());
        end
        @(negedge i_clk);
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
